// ===== hdl/buddy_block_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// buddy block allocator assertion macros
// property wrappers that compile away for synthesis
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bba implication check failed");
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bba next-cycle check failed");
`else
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and constants of the buddy block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int MAX_LEVELS_DEF = 10;
    localparam int ADDR_WIDTH_DEF = 32;
    localparam int DATA_W         = 32;
    localparam int NODE_OUT_W     = 10;
    localparam int LEVEL_REG_W    = 4;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_LEVELS = 2'd2;

    localparam logic [DATA_W-1:0]      POOL_BASE_RST   = 32'd0;
    localparam logic [DATA_W-1:0]      POOL_SIZE_RST   = 32'd1024;
    localparam logic [LEVEL_REG_W-1:0] TREE_LEVELS_RST = 4'd10;

    localparam logic FUNC_FREE = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LVL, S_LIM, S_POP, S_RU, S_RL, S_RR, S_MARK, S_ADDR,
        S_FCHK, S_FW, S_FRI, S_FRL, S_FEV, S_FCLR, S_FMS, S_FMR, S_FMP, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NOP, OP_CLEAR, OP_CAPTURE, OP_LVL, OP_LIM, OP_POP, OP_CHK_U, OP_CHK_L,
        OP_CHK_R, OP_MARK, OP_ADDR, OP_FCHK, OP_FIDX, OP_FCHK_IDX, OP_FCHK_L,
        OP_FEVAL, OP_FCLR, OP_FSIB, OP_FPAR, OP_RESULT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic fail;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_free;
        logic lvl_go;
        logic sp_zero;
        logic found;
        logic rdata;
        logic lc_gt_lim;
        logic mark_more;
        logic addr_last;
        logic out_range;
        logic idx_ge_len;
        logic lc_ge_len;
        logic hit;
        logic idx_zero;
        logic sib_ge_len;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba channel interfaces
// request, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if;
    import bba_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] release_address;
    modport source (output valid, func, request_size, release_address, input ready);
    modport sink   (input valid, func, request_size, release_address, output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  success;
    logic [DATA_W-1:0]     block_address;
    logic [NODE_OUT_W-1:0] node_index;
    modport source (output valid, success, block_address, node_index, input ready);
    modport sink   (input valid, success, block_address, node_index, output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer for the clear pass, allocate search and free walk
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    input  wire bba_pkg::t_sts i_sts,
    output bba_pkg::t_cmd      o_cmd
);
    import bba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_last) n_state = S_IDLE;
            S_IDLE: begin
                if (i_req_valid) n_state = i_sts.req_free ? S_FCHK : S_LVL;
            end
            S_LVL:   if (!i_sts.lvl_go) n_state = S_LIM;
            S_LIM:   n_state = S_POP;
            S_POP: begin
                if (!i_sts.sp_zero)   n_state = S_RU;
                else if (i_sts.found) n_state = S_MARK;
                else                  n_state = S_DONE;
            end
            S_RU: begin
                n_state = (i_sts.rdata && !i_sts.lc_gt_lim) ? S_RL : S_POP;
            end
            S_RL:    n_state = S_RR;
            S_RR:    n_state = S_POP;
            S_MARK:  if (!i_sts.mark_more) n_state = S_ADDR;
            S_ADDR:  if (i_sts.addr_last) n_state = S_DONE;
            S_FCHK:  n_state = i_sts.out_range ? S_DONE : S_FW;
            S_FW:    n_state = i_sts.idx_ge_len ? S_DONE : S_FRI;
            S_FRI: begin
                if (!i_sts.rdata)         n_state = S_DONE;
                else if (i_sts.lc_ge_len) n_state = S_FEV;
                else                      n_state = S_FRL;
            end
            S_FRL:   n_state = S_FEV;
            S_FEV:   n_state = i_sts.hit ? S_FCLR : S_FW;
            S_FCLR:  n_state = S_FMS;
            S_FMS: begin
                if (i_sts.idx_zero)        n_state = S_DONE;
                else if (i_sts.sib_ge_len) n_state = S_FMP;
                else                       n_state = S_FMR;
            end
            S_FMR:   n_state = i_sts.rdata ? S_DONE : S_FMP;
            S_FMP:   n_state = S_FMS;
            S_DONE:  if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '{op: OP_NOP, fail: 1'b0, in_ready: 1'b0};
        unique case (r_state)
            S_CLEAR: o_cmd.op = OP_CLEAR;
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_req_valid) o_cmd.op = OP_CAPTURE;
            end
            S_LVL:   o_cmd.op = OP_LVL;
            S_LIM:   o_cmd.op = OP_LIM;
            S_POP: begin
                o_cmd.op   = OP_POP;
                o_cmd.fail = i_sts.sp_zero && !i_sts.found;
            end
            S_RU:    o_cmd.op = OP_CHK_U;
            S_RL:    o_cmd.op = OP_CHK_L;
            S_RR:    o_cmd.op = OP_CHK_R;
            S_MARK:  o_cmd.op = OP_MARK;
            S_ADDR:  o_cmd.op = OP_ADDR;
            S_FCHK: begin
                o_cmd.op   = OP_FCHK;
                o_cmd.fail = i_sts.out_range;
            end
            S_FW: begin
                o_cmd.op   = OP_FIDX;
                o_cmd.fail = i_sts.idx_ge_len;
            end
            S_FRI: begin
                o_cmd.op   = OP_FCHK_IDX;
                o_cmd.fail = !i_sts.rdata;
            end
            S_FRL:   o_cmd.op = OP_FCHK_L;
            S_FEV:   o_cmd.op = OP_FEVAL;
            S_FCLR:  o_cmd.op = OP_FCLR;
            S_FMS:   o_cmd.op = OP_FSIB;
            S_FMR:   o_cmd.op = OP_NOP;
            S_FMP:   o_cmd.op = OP_FPAR;
            S_DONE:  if (!i_sts.out_busy) o_cmd.op = OP_RESULT;
            default: o_cmd.op = OP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// configuration registers, occupancy ram, search stack, free walk registers and result register
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dp #(
    parameter int MAX_LEVELS = bba_pkg::MAX_LEVELS_DEF,
    parameter int ADDR_WIDTH = bba_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire bba_pkg::t_cmd                      i_cmd,
    output bba_pkg::t_sts                           o_sts,
    input  wire logic                               i_cfg_we,
    input  wire logic [bba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [bba_pkg::DATA_W-1:0]         i_cfg_data,
    input  wire logic                               i_func,
    input  wire logic [bba_pkg::DATA_W-1:0]         i_request_size,
    input  wire logic [bba_pkg::DATA_W-1:0]         i_release_address,
    input  wire logic                               i_out_ready,
    output logic                                    o_out_valid,
    output logic                                    o_success,
    output logic [bba_pkg::DATA_W-1:0]              o_block_address,
    output logic [bba_pkg::NODE_OUT_W-1:0]          o_node_index
);
    import bba_pkg::*;

    localparam int NW         = MAX_LEVELS + 1;
    localparam int NODE_COUNT = (1 << MAX_LEVELS) - 1;
    localparam int RAM_AW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int SD         = MAX_LEVELS + 2;
    localparam int SPW        = $clog2(SD + 1);
    localparam int SAW        = $clog2(SD);
    localparam int LW         = $clog2(MAX_LEVELS + 1);
    localparam int KW         = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam logic [DATA_W-1:0] ADDR_MASK =
        (ADDR_WIDTH >= DATA_W) ? '1 : DATA_W'((64'd1 << ADDR_WIDTH) - 64'd1);

    logic [DATA_W-1:0]      r_pool_base;
    logic [DATA_W-1:0]      r_pool_size;
    logic [LEVEL_REG_W-1:0] r_tree_levels;

    logic                   r_func;
    logic [DATA_W-1:0]      r_req_size;
    logic [DATA_W-1:0]      r_rel;
    logic                   r_ok;
    logic [RAM_AW-1:0]      r_clr;
    logic [LW-1:0]          r_lvl;
    logic [NW-1:0]          r_lim;
    logic [NW-1:0]          r_stack [SD];
    logic [SPW-1:0]         r_sp;
    logic [NW-1:0]          r_u;
    logic                   r_lc_occ;
    logic [NW-1:0]          r_last;
    logic                   r_found;
    logic [NW-1:0]          r_cur;
    logic [KW-1:0]          r_k;
    logic                   r_started;
    logic [DATA_W-1:0]      r_half;
    logic [DATA_W-1:0]      r_acc;
    logic [DATA_W-1:0]      r_off;
    logic [DATA_W-1:0]      r_cur_off;
    logic [DATA_W-1:0]      r_cur_size;
    logic [NW-1:0]          r_idx;
    logic                   r_child_occ;
    logic [NW-1:0]          r_freed;
    logic                   r_out_valid;
    logic                   r_out_success;
    logic [DATA_W-1:0]      r_out_addr;
    logic [NODE_OUT_W-1:0]  r_out_node;

    logic [LW-1:0]          act_l;
    logic [NW-1:0]          len;
    logic [LW-1:0]          eff;
    logic [NW-1:0]          top;
    logic [NW-1:0]          lc_u;
    logic [NW-1:0]          lc_cur;
    logic [NW-1:0]          lc_f;
    logic [NW-1:0]          sib;
    logic [NW-1:0]          par;
    logic [MAX_LEVELS-1:0]  v;
    logic [DATA_W-1:0]      half_n;
    logic [DATA_W-1:0]      cs_n;
    logic [DATA_W:0]        mid;
    logic [DATA_W:0]        addr_sum;
    logic                   ram_we;
    logic [RAM_AW-1:0]      ram_waddr;
    logic                   ram_wdata;
    logic [RAM_AW-1:0]      ram_raddr;
    logic                   ram_rdata;

    bba_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_tree_levels == '0) begin
            act_l = LW'(1);
        end else if (32'(r_tree_levels) > 32'(MAX_LEVELS)) begin
            act_l = LW'(MAX_LEVELS);
        end else begin
            act_l = LW'(r_tree_levels);
        end
    end

    assign len      = (NW'(1) << act_l) - NW'(1);
    assign eff      = (r_lvl < act_l - LW'(1)) ? r_lvl : act_l - LW'(1);
    assign top      = r_stack[SAW'(r_sp - SPW'(1))];
    assign lc_u     = NW'({r_u, 1'b1});
    assign lc_cur   = NW'({r_cur, 1'b1});
    assign lc_f     = NW'({r_idx, 1'b1});
    assign sib      = r_idx[0] ? r_idx + NW'(1) : r_idx - NW'(1);
    assign par      = (r_idx - NW'(1)) >> 1;
    assign v        = MAX_LEVELS'(r_cur + NW'(1));
    assign half_n   = r_half >> 1;
    assign cs_n     = r_cur_size >> 1;
    assign mid      = {1'b0, r_cur_off} + {1'b0, cs_n};
    assign addr_sum = {1'b0, r_pool_base} + {1'b0, r_acc};

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = 1'b0;
        ram_raddr = '0;
        unique case (i_cmd.op)
            OP_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            OP_POP:      ram_raddr = RAM_AW'(top);
            OP_CHK_U:    ram_raddr = RAM_AW'(lc_u);
            OP_CHK_L:    ram_raddr = RAM_AW'(lc_u + NW'(1));
            OP_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = RAM_AW'(r_cur);
                ram_wdata = 1'b1;
            end
            OP_FIDX:     ram_raddr = RAM_AW'(r_idx);
            OP_FCHK_IDX: ram_raddr = RAM_AW'(lc_f);
            OP_FCLR: begin
                ram_we    = 1'b1;
                ram_waddr = RAM_AW'(r_idx);
            end
            OP_FSIB:     ram_raddr = RAM_AW'(sib);
            OP_FPAR: begin
                ram_we    = 1'b1;
                ram_waddr = RAM_AW'(par);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_sts.clr_last   = (r_clr == RAM_AW'(NODE_COUNT - 1));
        o_sts.req_free   = (i_func == FUNC_FREE);
        o_sts.lvl_go     = (r_lvl < act_l) &&
                           ((r_pool_size >> (r_lvl + LW'(1))) >= r_req_size);
        o_sts.sp_zero    = (r_sp == '0);
        o_sts.found      = r_found;
        o_sts.rdata      = ram_rdata;
        o_sts.lc_gt_lim  = (lc_u > r_lim);
        o_sts.mark_more  = (lc_cur <= r_lim);
        o_sts.addr_last  = (r_k == '0);
        o_sts.out_range  = (r_rel < r_pool_base) ||
                           ({1'b0, r_rel} >= ({1'b0, r_pool_base} + {1'b0, r_pool_size}));
        o_sts.idx_ge_len = (r_idx >= len);
        o_sts.lc_ge_len  = (lc_f >= len);
        o_sts.hit        = (r_off == r_cur_off) && !r_child_occ;
        o_sts.idx_zero   = (r_idx == '0);
        o_sts.sib_ge_len = (sib >= len);
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base   <= POOL_BASE_RST;
            r_pool_size   <= POOL_SIZE_RST;
            r_tree_levels <= TREE_LEVELS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POOL_BASE:   r_pool_base   <= i_cfg_data;
                CFG_POOL_SIZE:   r_pool_size   <= i_cfg_data;
                CFG_TREE_LEVELS: r_tree_levels <= LEVEL_REG_W'(i_cfg_data);
                default:         r_pool_base   <= r_pool_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_sp        <= '0;
            r_found     <= 1'b0;
            r_ok        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.fail) begin
                r_ok <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_CLEAR: r_clr <= r_clr + RAM_AW'(1);
                OP_CAPTURE: begin
                    r_ok    <= 1'b1;
                    r_found <= 1'b0;
                end
                OP_LIM: begin
                    r_stack[0] <= '0;
                    r_sp       <= SPW'(1);
                    r_found    <= 1'b0;
                end
                OP_POP: begin
                    if (r_sp != '0) begin
                        r_sp <= r_sp - SPW'(1);
                    end
                end
                OP_CHK_U: begin
                    if (!ram_rdata) begin
                        r_found <= 1'b1;
                    end
                end
                OP_CHK_R: begin
                    if ((r_lc_occ || ram_rdata) && (32'(r_sp) + 2 <= SD)) begin
                        r_stack[SAW'(r_sp)]           <= lc_u;
                        r_stack[SAW'(r_sp + SPW'(1))] <= lc_u + NW'(1);
                        r_sp                          <= r_sp + SPW'(2);
                    end
                end
                default: r_clr <= r_clr;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                r_func     <= i_func;
                r_req_size <= i_request_size;
                r_rel      <= i_release_address;
                r_lvl      <= '0;
            end
            OP_LVL: begin
                if (o_sts.lvl_go) begin
                    r_lvl <= r_lvl + LW'(1);
                end
            end
            OP_LIM: r_lim <= (NW'(1) << (eff + LW'(1))) - NW'(2);
            OP_POP: begin
                if (r_sp != '0) begin
                    r_u <= top;
                end else begin
                    r_cur <= r_last;
                end
            end
            OP_CHK_U: begin
                if (!ram_rdata) begin
                    r_last <= r_u;
                end
            end
            OP_CHK_L: r_lc_occ <= ram_rdata;
            OP_MARK: begin
                if (lc_cur <= r_lim) begin
                    r_cur <= lc_cur;
                end else begin
                    r_k       <= KW'(MAX_LEVELS - 1);
                    r_started <= 1'b0;
                    r_acc     <= '0;
                end
            end
            OP_ADDR: begin
                r_k <= r_k - KW'(1);
                if (!r_started) begin
                    if (v[r_k]) begin
                        r_started <= 1'b1;
                        r_half    <= r_pool_size;
                    end
                end else begin
                    r_half <= half_n;
                    if (v[r_k]) begin
                        r_acc <= r_acc + half_n;
                    end
                end
            end
            OP_FCHK: begin
                r_off      <= r_rel - r_pool_base;
                r_idx      <= '0;
                r_cur_off  <= '0;
                r_cur_size <= r_pool_size;
            end
            OP_FCHK_IDX: r_child_occ <= 1'b0;
            OP_FCHK_L:   r_child_occ <= ram_rdata;
            OP_FEVAL: begin
                r_cur_size <= cs_n;
                if (!o_sts.hit) begin
                    if ({1'b0, r_off} < mid) begin
                        r_idx <= lc_f;
                    end else begin
                        r_idx     <= lc_f + NW'(1);
                        r_cur_off <= mid[DATA_W-1:0];
                    end
                end
            end
            OP_FCLR: r_freed <= r_idx;
            OP_FPAR: r_idx   <= par;
            OP_RESULT: begin
                r_out_success <= r_ok;
                if (!r_ok) begin
                    r_out_addr <= '0;
                    r_out_node <= '0;
                end else if (r_func == FUNC_FREE) begin
                    r_out_addr <= '0;
                    r_out_node <= NODE_OUT_W'(r_freed);
                end else begin
                    r_out_addr <= addr_sum[DATA_W-1:0] & ADDR_MASK;
                    r_out_node <= NODE_OUT_W'(r_cur);
                end
            end
            default: r_lc_occ <= r_lc_occ;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_success       = r_out_success;
    assign o_block_address = r_out_addr;
    assign o_node_index    = r_out_node;

endmodule

`default_nettype wire

// ===== hdl/buddy_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// buddy allocator over a pool, one occupancy bit per heap-indexed tree node
// ----------------------------------------------------------------------------
// After reset the unit clears all 2^MAX_LEVELS - 1 entries of its occupancy
// ram (1023 at the default) and takes no request meanwhile; configuration
// writes are always taken. One request is handled at a time, and the work is
// done in steps over the occupancy ram, which has one write and one read
// port. An allocate first picks its level, then runs a depth-first search
// over the tree nodes, marks one node per level down to that level and
// forms the address bit by bit. A free walks down the tree to the block,
// clears it and merges free buddies upward level by level. The result sits
// in an output register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_block_allocator_unit_assert.svh"

module buddy_block_allocator_unit #(
    parameter int MAX_LEVELS = bba_pkg::MAX_LEVELS_DEF,
    parameter int ADDR_WIDTH = bba_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp,
    bba_cfg_if.sink   i_cfg
);
    import bba_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_rsp_fail;
    logic w_rsp_zero;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_cmd.in_ready;

    assign w_rsp_fail = o_rsp.valid && !o_rsp.success;
    assign w_rsp_zero = (o_rsp.block_address == '0) && (o_rsp.node_index == '0);

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bba_dp #(
        .MAX_LEVELS (MAX_LEVELS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_func            (i_req.func),
        .i_request_size    (i_req.request_size),
        .i_release_address (i_req.release_address),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_success         (o_rsp.success),
        .o_block_address   (o_rsp.block_address),
        .o_node_index      (o_rsp.node_index)
    );

    `BBA_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, w_rsp_fail, w_rsp_zero)
    `BBA_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `BBA_ASSERT_IMP(a_no_req_in_clear, i_clk, i_rst_n, w_cmd.op == OP_CLEAR, !i_req.ready)

endmodule

`default_nettype wire
